### design/token_lexer_assert.svh
// Assertion macros shared by the token lexer checker.
`ifndef TOKEN_LEXER_ASSERT_SVH
`define TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("token_lexer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("token_lexer assertion failed");

`endif

### design/tl_pkg.sv
// Types, constants and helper functions of the token lexer.
package tl_pkg;

    localparam int LINE_BITS_DEF = 24;
    localparam int TOKEN_LINE_W  = 24;
    localparam int MAX_RES       = 3;
    localparam int RES_CW        = 2;
    localparam int RQ_DEPTH      = 8;
    localparam int RQ_AW         = 3;
    localparam int RQ_CW         = 4;
    localparam int PADDR_W       = 3;
    localparam int REG_IDX_LSB   = 2;

    localparam logic [7:0]  MAX_LEN_RESET  = 8'd63;
    localparam logic [31:0] DEC_LIMIT      = 32'd429496729;
    localparam logic [31:0] HEX_LIMIT      = 32'h1000_0000;
    localparam logic [3:0]  DEC_LAST_DIGIT = 4'd5;
    localparam logic [4:0]  HEX_NONE       = 5'd16;
    localparam logic [7:0]  HEX_LETTER_OFS = 8'd10;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_A_UP       = 8'h41;
    localparam logic [7:0] CH_F_UP       = 8'h46;
    localparam logic [7:0] CH_X_UP       = 8'h58;
    localparam logic [7:0] CH_Z_UP       = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_A_LO       = 8'h61;
    localparam logic [7:0] CH_F_LO       = 8'h66;
    localparam logic [7:0] CH_X_LO       = 8'h78;
    localparam logic [7:0] CH_Z_LO       = 8'h7A;

    localparam logic RK_TEXT = 1'b0;
    localparam logic RK_END  = 1'b1;

    typedef enum logic [3:0] {
        M_INIT, M_IDENT, M_MINUS, M_SLASH, M_SLC,
        M_MLC, M_MLC_END, M_ZERO, M_DEC, M_HEX
    } t_mode;

    typedef enum logic [2:0] {
        TK_INVALID, TK_EOF, TK_COLON, TK_DOT,
        TK_EQUAL, TK_ARROW, TK_IDENT, TK_INTEGER
    } t_tok;

    typedef enum logic [1:0] {
        ER_NONE, ER_TOO_LONG, ER_OVERFLOW, ER_UNTERM
    } t_err;

    typedef enum logic [0:0] {
        REG_MAX_TOKEN_LENGTH
    } t_reg_idx;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              text_char;
        t_tok                    token_kind;
        logic [31:0]             value;
        logic [TOKEN_LINE_W-1:0] line;
        t_err                    err;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic [RES_CW-1:0]         count;
        t_result [MAX_RES-1:0]     res;
    } t_push;

    function automatic logic f_is_letter(input logic [7:0] c);
        return ((c >= CH_A_LO) && (c <= CH_Z_LO)) || ((c >= CH_A_UP) && (c <= CH_Z_UP));
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [4:0] f_hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = '0;
        if (f_is_digit(c)) begin
            return {1'b0, c[3:0]};
        end
        if ((c >= CH_A_LO) && (c <= CH_F_LO)) begin
            v = c - CH_A_LO + HEX_LETTER_OFS;
            return {1'b0, v[3:0]};
        end
        if ((c >= CH_A_UP) && (c <= CH_F_UP)) begin
            v = c - CH_A_UP + HEX_LETTER_OFS;
            return {1'b0, v[3:0]};
        end
        return HEX_NONE;
    endfunction

    function automatic t_result f_text(input logic [7:0] c);
        t_result r;
        r            = '0;
        r.kind       = RK_TEXT;
        r.text_char  = c;
        r.token_kind = TK_INVALID;
        r.err        = ER_NONE;
        return r;
    endfunction

    function automatic t_result f_end(input t_tok k, input logic [31:0] v,
                                      input logic [TOKEN_LINE_W-1:0] ln, input t_err e);
        t_result r;
        r            = '0;
        r.kind       = RK_END;
        r.token_kind = k;
        r.value      = v;
        r.line       = ln;
        r.err        = e;
        return r;
    endfunction

endpackage

### design/tl_cfg.sv
// Configuration register file of the token lexer.
module tl_cfg
    import tl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         o_max_len
);

    logic [7:0] r_max_len;
    logic       w_sel_max;

    assign w_sel_max = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_MAX_TOKEN_LENGTH);
    assign pready    = 1'b1;
    assign prdata    = w_sel_max ? {24'b0, r_max_len} : 32'b0;
    assign o_max_len = r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_len <= pwdata[7:0];
        end
    end

endmodule

### design/tl_step.sv
// Input register and scan state machine: one character per cycle, unless o_in_stall holds it, into up to three results.
module tl_step
    import tl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_in_char,
    input  logic             i_end_of_input,
    input  logic [7:0]       i_max_len,
    input  logic [RQ_CW-1:0] i_rq_count,
    output t_push            o_push
);

    logic                 r_in_valid;
    logic [7:0]           r_in_char;
    logic                 r_in_eof;
    t_mode                r_mode;
    logic [LINE_BITS-1:0] r_lc;
    logic [LINE_BITS-1:0] r_sl;
    logic [31:0]          r_acc;
    logic [7:0]           r_len;
    logic                 r_fin;

    logic                              w_in_take;
    logic [RQ_CW:0]                    w_need;
    logic [LINE_BITS+TOKEN_LINE_W-1:0] w_sl_ext;
    logic [LINE_BITS+TOKEN_LINE_W-1:0] w_lc_ext;
    logic [TOKEN_LINE_W-1:0]           w_old_line;
    logic [TOKEN_LINE_W-1:0]           w_cur_line;

    t_mode                 v_mode;
    logic [LINE_BITS-1:0]  v_lc;
    logic [LINE_BITS-1:0]  v_sl;
    logic [31:0]           v_acc;
    logic [7:0]            v_len;
    logic                  v_fin;
    logic [RES_CW-1:0]     v_cnt;
    t_result [MAX_RES-1:0] v_res;
    logic                  v_init;
    logic                  v_mlc;
    logic                  v_eof;
    logic [7:0]            v_c;
    logic [4:0]            v_hex;
    logic                  v_is_hex;
    logic                  v_dig_ok;
    logic                  v_over;

    assign w_need     = {1'b0, i_rq_count}
                      + (r_in_valid ? (RQ_CW + 1)'(2 * MAX_RES) : (RQ_CW + 1)'(MAX_RES));
    assign o_in_stall = (w_need > (RQ_CW + 1)'(RQ_DEPTH));
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_sl_ext   = {{TOKEN_LINE_W{1'b0}}, r_sl};
    assign w_lc_ext   = {{TOKEN_LINE_W{1'b0}}, r_lc};
    assign w_old_line = w_sl_ext[TOKEN_LINE_W-1:0];
    assign w_cur_line = w_lc_ext[TOKEN_LINE_W-1:0];

    always_comb begin
        v_mode   = r_mode;
        v_lc     = r_lc;
        v_sl     = r_sl;
        v_acc    = r_acc;
        v_len    = r_len;
        v_fin    = r_fin;
        v_cnt    = '0;
        v_res    = '0;
        v_init   = 1'b0;
        v_mlc    = 1'b0;
        v_eof    = r_in_eof;
        v_c      = r_in_char;
        v_hex    = f_hex_val(r_in_char);
        v_is_hex = (r_mode == M_HEX);
        v_dig_ok = 1'b0;
        v_over   = 1'b0;

        if (r_fin) begin
            if (v_eof) begin
                v_sl         = r_lc;
                v_res[v_cnt] = f_end(TK_EOF, 32'b0, w_cur_line, ER_NONE);
                v_cnt        = v_cnt + RES_CW'(1);
                v_acc        = '0;
                v_len        = '0;
                v_mode       = M_INIT;
            end
        end else begin
            unique case (r_mode)
                M_INIT: begin
                    v_init = 1'b1;
                end
                M_MINUS: begin
                    if (!v_eof && (v_c == CH_GT)) begin
                        v_res[v_cnt] = f_end(TK_ARROW, 32'b0, w_old_line, ER_NONE);
                    end else begin
                        v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_NONE);
                        v_init       = 1'b1;
                    end
                    v_cnt  = v_cnt + RES_CW'(1);
                    v_acc  = '0;
                    v_len  = '0;
                    v_mode = M_INIT;
                end
                M_SLASH: begin
                    if (!v_eof && (v_c == CH_SLASH)) begin
                        v_mode = M_SLC;
                    end else if (!v_eof && (v_c == CH_STAR)) begin
                        v_mode = M_MLC;
                    end else begin
                        v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_NONE);
                        v_cnt        = v_cnt + RES_CW'(1);
                        v_acc        = '0;
                        v_len        = '0;
                        v_mode       = M_INIT;
                        v_init       = 1'b1;
                    end
                end
                M_SLC: begin
                    if (v_eof) begin
                        v_mode = M_INIT;
                        v_init = 1'b1;
                    end else if (v_c == CH_LF) begin
                        if (v_lc != {LINE_BITS{1'b1}}) begin
                            v_lc = v_lc + LINE_BITS'(1);
                        end
                        v_mode = M_INIT;
                    end
                end
                M_MLC: begin
                    v_mlc = 1'b1;
                end
                M_MLC_END: begin
                    if (!v_eof && (v_c == CH_SLASH)) begin
                        v_mode = M_INIT;
                    end else begin
                        v_mode = M_MLC;
                        v_mlc  = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (!v_eof && (f_is_letter(v_c) || f_is_digit(v_c)
                                   || (v_c == CH_UNDERSCORE) || (v_c == CH_MINUS))) begin
                        if (v_len >= i_max_len) begin
                            v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_TOO_LONG);
                            v_acc        = '0;
                            v_len        = '0;
                            v_mode       = M_INIT;
                        end else begin
                            v_len        = v_len + 8'd1;
                            v_res[v_cnt] = f_text(v_c);
                        end
                    end else begin
                        v_res[v_cnt] = f_end(TK_IDENT, 32'b0, w_old_line, ER_NONE);
                        v_acc        = '0;
                        v_len        = '0;
                        v_mode       = M_INIT;
                        v_init       = 1'b1;
                    end
                    v_cnt = v_cnt + RES_CW'(1);
                end
                M_ZERO: begin
                    if (!v_eof && ((v_c == CH_X_LO) || (v_c == CH_X_UP))) begin
                        if (v_len >= i_max_len) begin
                            v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_TOO_LONG);
                            v_len        = '0;
                            v_mode       = M_INIT;
                        end else begin
                            v_len        = v_len + 8'd1;
                            v_res[v_cnt] = f_text(v_c);
                            v_mode       = M_HEX;
                        end
                    end else begin
                        if (!v_eof && (v_c >= CH_ONE) && (v_c <= CH_NINE)) begin
                            v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_NONE);
                        end else begin
                            v_res[v_cnt] = f_end(TK_INTEGER, 32'b0, w_old_line, ER_NONE);
                        end
                        v_len  = '0;
                        v_mode = M_INIT;
                        v_init = 1'b1;
                    end
                    v_acc = '0;
                    v_cnt = v_cnt + RES_CW'(1);
                end
                M_DEC, M_HEX: begin
                    v_dig_ok = v_is_hex ? !v_hex[4] : f_is_digit(v_c);
                    v_over   = v_is_hex ? (r_acc >= HEX_LIMIT)
                             : ((r_acc > DEC_LIMIT)
                                || ((r_acc == DEC_LIMIT) && (v_hex[3:0] > DEC_LAST_DIGIT)));
                    if (!v_eof && v_dig_ok) begin
                        if (v_len >= i_max_len) begin
                            v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_TOO_LONG);
                            v_acc        = '0;
                            v_len        = '0;
                            v_mode       = M_INIT;
                        end else if (v_over) begin
                            v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_old_line, ER_OVERFLOW);
                            v_acc        = '0;
                            v_len        = '0;
                            v_mode       = M_INIT;
                        end else begin
                            v_len        = v_len + 8'd1;
                            v_res[v_cnt] = f_text(v_c);
                            v_acc        = v_is_hex ? {r_acc[27:0], v_hex[3:0]}
                                         : ((r_acc << 3) + (r_acc << 1) + {28'b0, v_hex[3:0]});
                        end
                    end else begin
                        v_res[v_cnt] = f_end(TK_INTEGER, r_acc, w_old_line, ER_NONE);
                        v_acc        = '0;
                        v_len        = '0;
                        v_mode       = M_INIT;
                        v_init       = 1'b1;
                    end
                    v_cnt = v_cnt + RES_CW'(1);
                end
                default: begin
                    v_mode = M_INIT;
                    v_init = 1'b1;
                end
            endcase

            if (v_mlc) begin
                if (v_eof) begin
                    v_res[v_cnt] = f_end(TK_EOF, 32'b0, w_old_line, ER_UNTERM);
                    v_cnt        = v_cnt + RES_CW'(1);
                    v_acc        = '0;
                    v_len        = '0;
                    v_mode       = M_INIT;
                    v_fin        = 1'b1;
                end else if (v_c == CH_STAR) begin
                    v_mode = M_MLC_END;
                end else if (v_c == CH_LF) begin
                    if (v_lc != {LINE_BITS{1'b1}}) begin
                        v_lc = v_lc + LINE_BITS'(1);
                    end
                end
            end

            if (v_init) begin
                v_sl = v_lc;
                if (v_eof) begin
                    v_res[v_cnt] = f_end(TK_EOF, 32'b0, w_cur_line, ER_NONE);
                    v_cnt        = v_cnt + RES_CW'(1);
                    v_acc        = '0;
                    v_len        = '0;
                    v_mode       = M_INIT;
                    v_fin        = 1'b1;
                end else if ((v_c == CH_SPACE) || (v_c == CH_TAB) || (v_c == CH_CR)) begin
                    v_mode = M_INIT;
                end else if (v_c == CH_LF) begin
                    if (v_lc != {LINE_BITS{1'b1}}) begin
                        v_lc = v_lc + LINE_BITS'(1);
                    end
                end else if (v_c == CH_SLASH) begin
                    v_mode = M_SLASH;
                end else if (v_len >= i_max_len) begin
                    v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_cur_line, ER_TOO_LONG);
                    v_cnt        = v_cnt + RES_CW'(1);
                    v_acc        = '0;
                    v_len        = '0;
                    v_mode       = M_INIT;
                end else begin
                    v_len        = v_len + 8'd1;
                    v_res[v_cnt] = f_text(v_c);
                    v_cnt        = v_cnt + RES_CW'(1);
                    if ((v_c == CH_COLON) || (v_c == CH_DOT) || (v_c == CH_EQUAL)) begin
                        v_res[v_cnt] = f_end((v_c == CH_COLON) ? TK_COLON
                                             : ((v_c == CH_DOT) ? TK_DOT : TK_EQUAL),
                                             32'b0, w_cur_line, ER_NONE);
                        v_cnt        = v_cnt + RES_CW'(1);
                        v_acc        = '0;
                        v_len        = '0;
                        v_mode       = M_INIT;
                    end else if (v_c == CH_MINUS) begin
                        v_mode = M_MINUS;
                    end else if (f_is_letter(v_c)) begin
                        v_mode = M_IDENT;
                    end else if (v_c == CH_ZERO) begin
                        v_acc  = '0;
                        v_mode = M_ZERO;
                    end else if (f_is_digit(v_c)) begin
                        v_acc  = {28'b0, v_c[3:0]};
                        v_mode = M_DEC;
                    end else begin
                        v_res[v_cnt] = f_end(TK_INVALID, 32'b0, w_cur_line, ER_NONE);
                        v_cnt        = v_cnt + RES_CW'(1);
                        v_acc        = '0;
                        v_len        = '0;
                        v_mode       = M_INIT;
                    end
                end
            end
        end

        for (int i = 0; i < MAX_RES; i++) begin
            if ((RES_CW'(i) + RES_CW'(1)) == v_cnt) begin
                v_res[i].last = 1'b1;
            end
        end
    end

    assign o_push.count = r_in_valid ? v_cnt : '0;
    assign o_push.res   = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_INIT;
            r_lc       <= '0;
            r_sl       <= '0;
            r_acc      <= '0;
            r_len      <= '0;
            r_fin      <= 1'b0;
        end else begin
            r_in_valid <= w_in_take;
            if (r_in_valid) begin
                r_mode <= v_mode;
                r_lc   <= v_lc;
                r_sl   <= v_sl;
                r_acc  <= v_acc;
                r_len  <= v_len;
                r_fin  <= v_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_in_char;
            r_in_eof  <= i_end_of_input;
        end
    end

endmodule

### design/tl_fifo.sv
// Result queue: takes up to three results per cycle and hands out one beat per cycle unless i_stall holds it.
module tl_fifo
    import tl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    input  logic             i_stall,
    output logic             o_valid,
    output t_result          o_head,
    output logic [RQ_CW-1:0] o_count
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr;
    logic [RQ_AW-1:0] r_rd;
    logic [RQ_CW-1:0] r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_CW'(i) < i_push.count) begin
                r_mem[r_wr + RQ_AW'(i)] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + RQ_AW'(i_push.count);
            r_rd    <= r_rd + RQ_AW'(w_pop);
            r_count <= r_count + RQ_CW'(i_push.count) - RQ_CW'(w_pop);
        end
    end

endmodule

### design/token_lexer.sv
// Token lexer top level: character channel in, token result beats out, one config register.
//
// Input channel: one character, or an end-of-input mark, per beat on i_in_valid / o_in_stall.
// Output channel: one result beat per cycle on o_out_valid / i_out_stall; each beat is a
// text character or a token end, and o_last_of_run marks the final beat of one character.
// A character gives zero to three beats.
// The character is registered at acceptance and scanned in the following cycle; the scan
// writes its beats into the result queue, and the first beat is offered on the output
// from the queue head.
// Throughput: one character per cycle while o_in_stall is low. The scan state is updated
// for each accepted character, so characters can follow back to back; the output side moves
// one beat per cycle, while i_out_stall is low, through an eight-entry result queue.
// o_in_stall rises when the queue could not hold the worst case of the character in
// the scan register plus one more, so a stalled receiver eventually stalls the sender
// without losing beats.
// max_token_length is written over the APB port at byte address 0, by the user only while
// the block is idle; the block does not enforce this. Reset clears the scan state, the line
// counter and the queue, and loads max_token_length with 63.
module token_lexer
    import tl_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_in_char,
    input  logic                    i_end_of_input,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_result_kind,
    output logic [7:0]              o_text_char,
    output logic [2:0]              o_token_kind,
    output logic [31:0]             o_token_value,
    output logic [TOKEN_LINE_W-1:0] o_token_line,
    output logic [1:0]              o_error_code,
    output logic                    o_last_of_run,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [7:0]       w_max_len;
    logic [RQ_CW-1:0] w_rq_count;
    t_push            w_push;
    t_result          w_head;

    tl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    tl_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .i_max_len      (w_max_len),
        .i_rq_count     (w_rq_count),
        .o_push         (w_push)
    );

    tl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_head  (w_head),
        .o_count (w_rq_count)
    );

    assign o_result_kind = w_head.kind;
    assign o_text_char   = w_head.text_char;
    assign o_token_kind  = w_head.token_kind;
    assign o_token_value = w_head.value;
    assign o_token_line  = w_head.line;
    assign o_error_code  = w_head.err;
    assign o_last_of_run = w_head.last;

endmodule

### design/tl_checker.sv
// Port-level checker of the token lexer and its bind to the top level.
`include "token_lexer_assert.svh"

module tl_checker
    import tl_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic                    o_result_kind,
    input logic [7:0]              o_text_char,
    input logic [2:0]              o_token_kind,
    input logic [31:0]             o_token_value,
    input logic [TOKEN_LINE_W-1:0] o_token_line,
    input logic [1:0]              o_error_code,
    input logic                    o_last_of_run
);

    logic w_text_beat;
    logic w_end_beat;

    assign w_text_beat = o_out_valid && (o_result_kind == RK_TEXT);
    assign w_end_beat  = o_out_valid && (o_result_kind == RK_END);

    `TL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_kind) && $stable(o_text_char) && $stable(o_token_kind) && $stable(o_token_value) && $stable(o_token_line) && $stable(o_error_code) && $stable(o_last_of_run))

    `TL_ASSERT_IMP(a_text_clean, i_clk, i_rst_n, w_text_beat, (o_token_kind == TK_INVALID) && (o_token_value == 32'b0) && (o_token_line == '0) && (o_error_code == ER_NONE))

    `TL_ASSERT_IMP(a_value_int, i_clk, i_rst_n, w_end_beat && (o_token_kind != TK_INTEGER), o_token_value == 32'b0)

    `TL_ASSERT_IMP(a_err_kind, i_clk, i_rst_n, w_end_beat && (o_error_code != ER_NONE), ((o_error_code == ER_UNTERM) && (o_token_kind == TK_EOF)) || ((o_error_code != ER_UNTERM) && (o_token_kind == TK_INVALID) && (o_token_value == 32'b0)))

endmodule

bind token_lexer tl_checker u_tl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_text_char   (o_text_char),
    .o_token_kind  (o_token_kind),
    .o_token_value (o_token_value),
    .o_token_line  (o_token_line),
    .o_error_code  (o_error_code),
    .o_last_of_run (o_last_of_run)
);

### tb/sv/tb_token_lexer.sv
// Self-checking testbench of the token lexer: predicted result beats against the block's.
`timescale 1ns / 100ps

module tb_token_lexer;
    import tl_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_CAP    = 100;
    localparam logic [PADDR_W-1:0] LENGTH_ADDR =
        PADDR_W'(int'(REG_MAX_TOKEN_LENGTH) << REG_IDX_LSB);

    class lex_book;
        t_mode                   mode;
        logic [TOKEN_LINE_W-1:0] line_cnt;
        logic [TOKEN_LINE_W-1:0] tok_line;
        logic [31:0]             acc;
        logic [7:0]              len;
        logic [7:0]              max_len;
        bit                      finished;
        t_result                 beats_due[$];
        t_result                 step_beats[$];
        int                      errors;
        int                      beats_seen;
        int                      ends_seen;
        int                      flagged_seen;

        function new();
            mode         = M_INIT;
            line_cnt     = '0;
            tok_line     = '0;
            acc          = '0;
            len          = '0;
            max_len      = MAX_LEN_RESET;
            finished     = 1'b0;
            errors       = 0;
            beats_seen   = 0;
            ends_seen    = 0;
            flagged_seen = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function logic [4:0] hex_digit(logic [7:0] c);
            if (is_digit(c)) begin
                return {1'b0, c[3:0]};
            end
            if (c >= CH_A_LO && c <= CH_F_LO) begin
                return 5'(c - CH_A_LO) + 5'd10;
            end
            if (c >= CH_A_UP && c <= CH_F_UP) begin
                return 5'(c - CH_A_UP) + 5'd10;
            end
            return HEX_NONE;
        endfunction

        function void emit(t_result r);
            if (step_beats.size() < MAX_RES) begin
                step_beats.push_back(r);
            end
        endfunction

        function void emit_text(logic [7:0] c);
            t_result r;
            r           = '0;
            r.kind      = RK_TEXT;
            r.text_char = c;
            emit(r);
        endfunction

        function void close_token(t_tok k, logic [31:0] v, t_err e);
            t_result r;
            r            = '0;
            r.kind       = RK_END;
            r.token_kind = k;
            r.value      = v;
            r.line       = tok_line;
            r.err        = e;
            emit(r);
            acc  = '0;
            len  = '0;
            mode = M_INIT;
        endfunction

        function void bump_line();
            if (line_cnt != '1) begin
                line_cnt++;
            end
        endfunction

        function bit take(logic [7:0] c);
            if (len >= max_len) begin
                close_token(TK_INVALID, '0, ER_TOO_LONG);
                return 1'b0;
            end
            len++;
            emit_text(c);
            return 1'b1;
        endfunction

        function void push_digit(logic [7:0] c, bit hex);
            logic [4:0] d;
            bit         over;
            d = hex ? hex_digit(c) : {1'b0, c[3:0]};
            if (len >= max_len) begin
                close_token(TK_INVALID, '0, ER_TOO_LONG);
                return;
            end
            if (hex) begin
                over = acc >= HEX_LIMIT;
            end else begin
                over = acc > DEC_LIMIT || (acc == DEC_LIMIT && d > 5'(DEC_LAST_DIGIT));
            end
            if (over) begin
                close_token(TK_INVALID, '0, ER_OVERFLOW);
                return;
            end
            len++;
            emit_text(c);
            acc = hex ? {acc[27:0], d[3:0]} : acc * 32'd10 + 32'(d);
        endfunction

        function void scan_char(logic [7:0] c, logic eof);
            bit done;
            int iter;
            step_beats.delete();
            done = 1'b0;
            if (finished) begin
                if (eof) begin
                    tok_line = line_cnt;
                    close_token(TK_EOF, '0, ER_NONE);
                end
                done = 1'b1;
            end
            for (iter = 0; iter < 6 && !done; iter++) begin
                done = 1'b1;
                case (mode)
                    M_INIT: begin
                        tok_line = line_cnt;
                        if (eof) begin
                            close_token(TK_EOF, '0, ER_NONE);
                            finished = 1'b1;
                        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                        end else if (c == CH_LF) begin
                            bump_line();
                        end else if (c == CH_COLON || c == CH_DOT || c == CH_EQUAL) begin
                            if (take(c)) begin
                                close_token((c == CH_COLON) ? TK_COLON :
                                            ((c == CH_DOT) ? TK_DOT : TK_EQUAL), '0, ER_NONE);
                            end
                        end else if (c == CH_SLASH) begin
                            mode = M_SLASH;
                        end else if (c == CH_MINUS) begin
                            if (take(c)) begin
                                mode = M_MINUS;
                            end
                        end else if (is_letter(c)) begin
                            if (take(c)) begin
                                mode = M_IDENT;
                            end
                        end else if (c == CH_ZERO) begin
                            if (take(c)) begin
                                acc  = '0;
                                mode = M_ZERO;
                            end
                        end else if (is_digit(c)) begin
                            if (take(c)) begin
                                acc  = 32'(c[3:0]);
                                mode = M_DEC;
                            end
                        end else begin
                            if (take(c)) begin
                                close_token(TK_INVALID, '0, ER_NONE);
                            end
                        end
                    end
                    M_MINUS: begin
                        if (!eof && c == CH_GT) begin
                            close_token(TK_ARROW, '0, ER_NONE);
                        end else begin
                            close_token(TK_INVALID, '0, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    M_SLASH: begin
                        if (!eof && c == CH_SLASH) begin
                            mode = M_SLC;
                        end else if (!eof && c == CH_STAR) begin
                            mode = M_MLC;
                        end else begin
                            close_token(TK_INVALID, '0, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    M_SLC: begin
                        if (eof) begin
                            mode = M_INIT;
                            done = 1'b0;
                        end else if (c == CH_LF) begin
                            bump_line();
                            mode = M_INIT;
                        end
                    end
                    M_MLC: begin
                        if (eof) begin
                            close_token(TK_EOF, '0, ER_UNTERM);
                            finished = 1'b1;
                        end else if (c == CH_STAR) begin
                            mode = M_MLC_END;
                        end else if (c == CH_LF) begin
                            bump_line();
                        end
                    end
                    M_MLC_END: begin
                        if (!eof && c == CH_SLASH) begin
                            mode = M_INIT;
                        end else begin
                            mode = M_MLC;
                            done = 1'b0;
                        end
                    end
                    M_IDENT: begin
                        if (!eof && (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE ||
                                     c == CH_MINUS)) begin
                            void'(take(c));
                        end else begin
                            close_token(TK_IDENT, '0, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    M_ZERO: begin
                        if (!eof && (c == CH_X_LO || c == CH_X_UP)) begin
                            if (take(c)) begin
                                acc  = '0;
                                mode = M_HEX;
                            end
                        end else if (!eof && c >= CH_ONE && c <= CH_NINE) begin
                            close_token(TK_INVALID, '0, ER_NONE);
                            done = 1'b0;
                        end else begin
                            close_token(TK_INTEGER, '0, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    M_DEC: begin
                        if (!eof && is_digit(c)) begin
                            push_digit(c, 1'b0);
                        end else begin
                            close_token(TK_INTEGER, acc, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    M_HEX: begin
                        if (!eof && hex_digit(c) != HEX_NONE) begin
                            push_digit(c, 1'b1);
                        end else begin
                            close_token(TK_INTEGER, acc, ER_NONE);
                            done = 1'b0;
                        end
                    end
                    default: begin
                        mode = M_INIT;
                        done = 1'b0;
                    end
                endcase
            end
            if (step_beats.size() > 0) begin
                step_beats[step_beats.size() - 1].last = 1'b1;
            end
            foreach (step_beats[i]) begin
                beats_due.push_back(step_beats[i]);
            end
        endfunction

        function void field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: result beat with none expected, actual kind %0d token %0d",
                             $time, got.kind, got.token_kind);
                end
                return;
            end
            want = beats_due.pop_front();
            beats_seen++;
            if (want.kind == RK_END) begin
                ends_seen++;
                if (want.err != ER_NONE) begin
                    flagged_seen++;
                end
            end
            field_ok("result_kind", 32'(want.kind), 32'(got.kind));
            field_ok("text_char", 32'(want.text_char), 32'(got.text_char));
            field_ok("token_kind", 32'(want.token_kind), 32'(got.token_kind));
            field_ok("token_value", want.value, got.value);
            field_ok("token_line", 32'(want.line), 32'(got.line));
            field_ok("error_code", 32'(want.err), 32'(got.err));
            field_ok("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [7:0]              i_in_char;
    logic                    i_end_of_input;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_result_kind;
    logic [7:0]              o_text_char;
    logic [2:0]              o_token_kind;
    logic [31:0]             o_token_value;
    logic [TOKEN_LINE_W-1:0] o_token_line;
    logic [1:0]              o_error_code;
    logic                    o_last_of_run;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    lex_book    book;
    logic [7:0] chunk[$];
    int         sent;
    int         marks;
    int         limits_used;
    int         send_idle_pct;
    int         stall_pct;
    int         cycles;

    token_lexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_text_char    (o_text_char),
        .o_token_kind   (o_token_kind),
        .o_token_value  (o_token_value),
        .o_token_line   (o_token_line),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                book.scan_char(i_in_char, i_end_of_input);
            end
            if (o_out_valid && !i_out_stall) begin
                seen            = '0;
                seen.kind       = o_result_kind;
                seen.text_char  = o_text_char;
                seen.token_kind = t_tok'(o_token_kind);
                seen.value      = o_token_value;
                seen.line       = o_token_line;
                seen.err        = t_err'(o_error_code);
                seen.last       = o_last_of_run;
                book.check_beat(seen);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eof);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_char      <= c;
        i_end_of_input <= eof;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent++;
        if (eof) begin
            marks++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_chunk();
        while (chunk.size() > 0) begin
            send_char(chunk.pop_front(), 1'b0);
        end
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (book.beats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic read_length(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LENGTH_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(v)) begin
            book.errors++;
            $display("%0t: max_token_length read mismatch, expected %0h, actual %0h",
                     $time, 32'(v), prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_length(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.max_len = v;
        limits_used++;
        @(negedge i_clk);
        read_length(v);
    endtask

    function automatic void add_text(string s);
        foreach (s[i]) begin
            chunk.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] letter();
        return ($urandom_range(0, 1) != 0) ? CH_A_LO + 8'($urandom_range(0, 25))
                                           : CH_A_UP + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return letter();
        end else if (r < 8) begin
            return CH_ZERO + 8'($urandom_range(0, 9));
        end else if (r == 8) begin
            return CH_UNDERSCORE;
        end
        return CH_MINUS;
    endfunction

    // One token or comment with random content, possibly ill-formed, or a noise byte,
    // followed by an optional separator.
    function automatic void queue_token();
        string       hex_set;
        string       s;
        logic [63:0] v;
        int          pick;
        int          n;
        hex_set = "0123456789abcdefABCDEF";
        pick    = $urandom_range(0, 99);
        if (pick < 25) begin
            chunk.push_back(letter());
            if (book.max_len <= 40 && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(int'(book.max_len) - 1, int'(book.max_len) + 2);
            end else begin
                n = $urandom_range(0, 6);
            end
            repeat (n) chunk.push_back(ident_char());
        end else if (pick < 40) begin
            case ($urandom_range(0, 3))
                0: v = 64'($urandom_range(1, 999));
                1: v = 64'd4294967295 - 64'($urandom_range(0, 5));
                2: v = 64'd4294967296 + 64'($urandom_range(0, 99));
                default: v = {32'd0, $urandom()} * 64'd10 + 64'($urandom_range(0, 9));
            endcase
            s = $sformatf("%0d", v);
            add_text(s);
        end else if (pick < 50) begin
            chunk.push_back(CH_ZERO);
            chunk.push_back(($urandom_range(0, 1) != 0) ? CH_X_LO : CH_X_UP);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 9) : $urandom_range(0, 4);
            repeat (n) chunk.push_back(hex_set[$urandom_range(0, 21)]);
        end else if (pick < 55) begin
            chunk.push_back(CH_ZERO);
            case ($urandom_range(0, 2))
                0: chunk.push_back(CH_ONE + 8'($urandom_range(0, 8)));
                1: chunk.push_back(CH_ZERO);
                default: begin
                end
            endcase
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: add_text(":");
                1: add_text(".");
                2: add_text("=");
                3: add_text("->");
                4: add_text("-");
                default: add_text("/");
            endcase
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: chunk.push_back(CH_SPACE);
                1: chunk.push_back(CH_TAB);
                2: chunk.push_back(CH_CR);
                default: chunk.push_back(CH_LF);
            endcase
        end else if (pick < 86) begin
            add_text("//");
            repeat ($urandom_range(0, 6)) chunk.push_back(8'($urandom_range(32, 126)));
            chunk.push_back(CH_LF);
        end else if (pick < 92) begin
            add_text("/*");
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 9))
                    0, 1: chunk.push_back(CH_STAR);
                    2: chunk.push_back(CH_LF);
                    3: chunk.push_back(CH_SLASH);
                    default: chunk.push_back(8'($urandom_range(32, 126)));
                endcase
            end
            add_text("*/");
        end else begin
            chunk.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            5, 6, 7: chunk.push_back(CH_SPACE);
            8: chunk.push_back(CH_LF);
            9: chunk.push_back(($urandom_range(0, 1) != 0) ? CH_TAB : CH_CR);
            default: begin
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        int goal;
        int half;
        bit paused;
        goal   = sent + count;
        half   = sent + count / 2;
        paused = 1'b0;
        while (sent < goal) begin
            queue_token();
            send_chunk();
            if (!paused && sent >= half) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    // The first end mark finishes the lexer and lands in a random scan state; later
    // characters are ignored, while each later end mark gives one more end-of-input token.
    task automatic close_input();
        case ($urandom_range(0, 6))
            0: add_text("abc");
            1: add_text("12");
            2: add_text("//x");
            3: add_text("/*x\n");
            4: add_text("-");
            5: add_text("/");
            default: begin
            end
        endcase
        send_chunk();
        send_char(8'($urandom_range(0, 255)), 1'b1);
        send_char(CH_A_LO, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_char      = '0;
        i_end_of_input = 1'b0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        book           = new();
        sent           = 0;
        marks          = 0;
        limits_used    = 1;
        send_idle_pct  = 0;
        stall_pct      = 0;
        cycles         = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        read_length(MAX_LEN_RESET);

        add_text("A_-9:.=->-a/:07 0x;");
        chunk.push_back(8'hFF);
        add_text("//\n\t");
        send_chunk();
        hold_until_drained();
        write_length(8'd2);
        add_text("abc 0x1 ");
        send_chunk();
        hold_until_drained();

        write_length(8'd255);
        run_random(100);
        hold_until_drained();

        write_length(8'd1);
        send_idle_pct = 70;
        run_random(80);
        hold_until_drained();

        write_length(8'($urandom_range(3, 16)));
        send_idle_pct = 0;
        stall_pct     = 70;
        run_random(110);
        hold_until_drained();

        write_length(MAX_LEN_RESET);
        send_idle_pct = 17;
        stall_pct     = 17;
        run_random(110);
        close_input();
        hold_until_drained();

        $display("Sent %0d characters and %0d end marks under %0d token length limits,",
                 sent - marks, marks, limits_used);
        $display("checked %0d result beats with %0d token ends, %0d of them flagged.",
                 book.beats_seen, book.ends_seen, book.flagged_seen);
        if (book.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tl_pkg.sv
design/tl_cfg.sv
design/tl_step.sv
design/tl_fifo.sv
design/token_lexer.sv
design/tl_checker.sv
tb/sv/tb_token_lexer.sv
